// ----- hdl/fepr_pkg.sv -----
// Shared types, register indexes and substitution tables of the index permuter.
`timescale 1ns / 1ps
package fepr_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned MixW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned RoundCntW = 7;
  localparam int unsigned PassW = 17;
  localparam logic [PassW-1:0] WALK_LIMIT = 17'd65536;

  localparam logic [CfgIdxW-1:0] REG_DOMAIN_RANGE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LOW_HALF_BITS = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_HIGH_HALF_BITS = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ROUND_COUNT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_KEY_SEED = 3'd4;

  typedef struct packed {
    logic load_in;
    logic load_c;
    logic do_round;
    logic round_odd;
    logic combine;
    logic load_out;
    logic out_zero;
  } dp_cmd_t;

  typedef struct packed {
    logic below;
  } dp_status_t;

  typedef logic [MixW-1:0] sbox_row_t [64];

  localparam sbox_row_t SP0 = '{
    32'h01010400,32'h00000000,32'h00010000,32'h01010404,32'h01010004,32'h00010404,32'h00000004,32'h00010000,
    32'h00000400,32'h01010400,32'h01010404,32'h00000400,32'h01000404,32'h01010004,32'h01000000,32'h00000004,
    32'h00000404,32'h01000400,32'h01000400,32'h00010400,32'h00010400,32'h01010000,32'h01010000,32'h01000404,
    32'h00010004,32'h01000004,32'h01000004,32'h00010004,32'h00000000,32'h00000404,32'h00010404,32'h01000000,
    32'h00010000,32'h01010404,32'h00000004,32'h01010000,32'h01010400,32'h01000000,32'h01000000,32'h00000400,
    32'h01010004,32'h00010000,32'h00010400,32'h01000004,32'h00000400,32'h00000004,32'h01000404,32'h00010404,
    32'h01010404,32'h00010004,32'h01010000,32'h01000404,32'h01000004,32'h00000404,32'h00010404,32'h01010400,
    32'h00000404,32'h01000400,32'h01000400,32'h00000000,32'h00010004,32'h00010400,32'h00000000,32'h01010004};
  localparam sbox_row_t SP1 = '{
    32'h80108020,32'h80008000,32'h00008000,32'h00108020,32'h00100000,32'h00000020,32'h80100020,32'h80008020,
    32'h80000020,32'h80108020,32'h80108000,32'h80000000,32'h80008000,32'h00100000,32'h00000020,32'h80100020,
    32'h00108000,32'h00100020,32'h80008020,32'h00000000,32'h80000000,32'h00008000,32'h00108020,32'h80100000,
    32'h00100020,32'h80000020,32'h00000000,32'h00108000,32'h00008020,32'h80108000,32'h80100000,32'h00008020,
    32'h00000000,32'h00108020,32'h80100020,32'h00100000,32'h80008020,32'h80100000,32'h80108000,32'h00008000,
    32'h80100000,32'h80008000,32'h00000020,32'h80108020,32'h00108020,32'h00000020,32'h00008000,32'h80000000,
    32'h00008020,32'h80108000,32'h00100000,32'h80000020,32'h00100020,32'h80008020,32'h80000020,32'h00100020,
    32'h00108000,32'h00000000,32'h80008000,32'h00008020,32'h80000000,32'h80100020,32'h80108020,32'h00108000};
  localparam sbox_row_t SP2 = '{
    32'h00000208,32'h08020200,32'h00000000,32'h08020008,32'h08000200,32'h00000000,32'h00020208,32'h08000200,
    32'h00020008,32'h08000008,32'h08000008,32'h00020000,32'h08020208,32'h00020008,32'h08020000,32'h00000208,
    32'h08000000,32'h00000008,32'h08020200,32'h00000200,32'h00020200,32'h08020000,32'h08020008,32'h00020208,
    32'h08000208,32'h00020200,32'h00020000,32'h08000208,32'h00000008,32'h08020208,32'h00000200,32'h08000000,
    32'h08020200,32'h08000000,32'h00020008,32'h00000208,32'h00020000,32'h08020200,32'h08000200,32'h00000000,
    32'h00000200,32'h00020008,32'h08020208,32'h08000200,32'h08000008,32'h00000200,32'h00000000,32'h08020008,
    32'h08000208,32'h00020000,32'h08000000,32'h08020208,32'h00000008,32'h00020208,32'h00020200,32'h08000008,
    32'h08020000,32'h08000208,32'h00000208,32'h08020000,32'h00020208,32'h00000008,32'h08020008,32'h00020200};
  localparam sbox_row_t SP3 = '{
    32'h00802001,32'h00002081,32'h00002081,32'h00000080,32'h00802080,32'h00800081,32'h00800001,32'h00002001,
    32'h00000000,32'h00802000,32'h00802000,32'h00802081,32'h00000081,32'h00000000,32'h00800080,32'h00800001,
    32'h00000001,32'h00002000,32'h00800000,32'h00802001,32'h00000080,32'h00800000,32'h00002001,32'h00002080,
    32'h00800081,32'h00000001,32'h00002080,32'h00800080,32'h00002000,32'h00802080,32'h00802081,32'h00000081,
    32'h00800080,32'h00800001,32'h00802000,32'h00802081,32'h00000081,32'h00000000,32'h00000000,32'h00802000,
    32'h00002080,32'h00800080,32'h00800081,32'h00000001,32'h00802001,32'h00002081,32'h00002081,32'h00000080,
    32'h00802081,32'h00000081,32'h00000001,32'h00002000,32'h00800001,32'h00002001,32'h00802080,32'h00800081,
    32'h00002001,32'h00002080,32'h00800000,32'h00802001,32'h00000080,32'h00800000,32'h00002000,32'h00802080};
  localparam sbox_row_t SP4 = '{
    32'h00000100,32'h02080100,32'h02080000,32'h42000100,32'h00080000,32'h00000100,32'h40000000,32'h02080000,
    32'h40080100,32'h00080000,32'h02000100,32'h40080100,32'h42000100,32'h42080000,32'h00080100,32'h40000000,
    32'h02000000,32'h40080000,32'h40080000,32'h00000000,32'h40000100,32'h42080100,32'h42080100,32'h02000100,
    32'h42080000,32'h40000100,32'h00000000,32'h42000000,32'h02080100,32'h02000000,32'h42000000,32'h00080100,
    32'h00080000,32'h42000100,32'h00000100,32'h02000000,32'h40000000,32'h02080000,32'h42000100,32'h40080100,
    32'h02000100,32'h40000000,32'h42080000,32'h02080100,32'h40080100,32'h00000100,32'h02000000,32'h42080000,
    32'h42080100,32'h00080100,32'h42000000,32'h42080100,32'h02080000,32'h00000000,32'h40080000,32'h42000000,
    32'h00080100,32'h02000100,32'h40000100,32'h00080000,32'h00000000,32'h40080000,32'h02080100,32'h40000100};
  localparam sbox_row_t SP5 = '{
    32'h20000010,32'h20400000,32'h00004000,32'h20404010,32'h20400000,32'h00000010,32'h20404010,32'h00400000,
    32'h20004000,32'h00404010,32'h00400000,32'h20000010,32'h00400010,32'h20004000,32'h20000000,32'h00004010,
    32'h00000000,32'h00400010,32'h20004010,32'h00004000,32'h00404000,32'h20004010,32'h00000010,32'h20400010,
    32'h20400010,32'h00000000,32'h00404010,32'h20404000,32'h00004010,32'h00404000,32'h20404000,32'h20000000,
    32'h20004000,32'h00000010,32'h20400010,32'h00404000,32'h20404010,32'h00400000,32'h00004010,32'h20000010,
    32'h00400000,32'h20004000,32'h20000000,32'h00004010,32'h20000010,32'h20404010,32'h00404000,32'h20400000,
    32'h00404010,32'h20404000,32'h00000000,32'h20400010,32'h00000010,32'h00004000,32'h20400000,32'h00404010,
    32'h00004000,32'h00400010,32'h20004010,32'h00000000,32'h20404000,32'h20000000,32'h00400010,32'h20004010};
  localparam sbox_row_t SP6 = '{
    32'h00200000,32'h04200002,32'h04000802,32'h00000000,32'h00000800,32'h04000802,32'h00200802,32'h04200800,
    32'h04200802,32'h00200000,32'h00000000,32'h04000002,32'h00000002,32'h04000000,32'h04200002,32'h00000802,
    32'h04000800,32'h00200802,32'h00200002,32'h04000800,32'h04000002,32'h04200000,32'h04200800,32'h00200002,
    32'h04200000,32'h00000800,32'h00000802,32'h04200802,32'h00200800,32'h00000002,32'h04000000,32'h00200800,
    32'h04000000,32'h00200800,32'h00200000,32'h04000802,32'h04000802,32'h04200002,32'h04200002,32'h00000002,
    32'h00200002,32'h04000000,32'h04000800,32'h00200000,32'h04200800,32'h00000802,32'h00200802,32'h04200800,
    32'h00000802,32'h04000002,32'h04200802,32'h04200000,32'h00200800,32'h00000000,32'h00000002,32'h04200802,
    32'h00000000,32'h00200802,32'h04200000,32'h00000800,32'h04000002,32'h04000800,32'h00000800,32'h00200002};
  localparam sbox_row_t SP7 = '{
    32'h10001040,32'h00001000,32'h00040000,32'h10041040,32'h10000000,32'h10001040,32'h00000040,32'h10000000,
    32'h00040040,32'h10040000,32'h10041040,32'h00041000,32'h10041000,32'h00041040,32'h00001000,32'h00000040,
    32'h10040000,32'h10000040,32'h10001000,32'h00001040,32'h00041000,32'h00040040,32'h10040040,32'h10041000,
    32'h00001040,32'h00000000,32'h00000000,32'h10040040,32'h10000040,32'h10001000,32'h00041040,32'h00040000,
    32'h00041040,32'h00040000,32'h10041000,32'h00001000,32'h00000040,32'h10040040,32'h00001000,32'h00041040,
    32'h10001000,32'h00000040,32'h10000040,32'h10040000,32'h10040040,32'h10000000,32'h00040000,32'h10001040,
    32'h00000000,32'h10041040,32'h00040040,32'h10000040,32'h10040000,32'h10001000,32'h10001040,32'h00000000,
    32'h10041040,32'h00041000,32'h00041000,32'h00001040,32'h00001040,32'h00040040,32'h10000000,32'h10041000};

  // Round function: four table entries picked from the low four bytes of t.
  function automatic logic [MixW-1:0] round_mix(input logic [DataW-1:0] t, input logic odd);
    logic [MixW-1:0] res;
    if (odd) begin
      res = SP7[t[5:0]] ^ SP5[t[13:8]] ^ SP3[t[21:16]] ^ SP1[t[29:24]];
    end else begin
      res = SP6[t[5:0]] ^ SP4[t[13:8]] ^ SP2[t[21:16]] ^ SP0[t[29:24]];
    end
    return res;
  endfunction

endpackage

// ----- hdl/feistel_index_permuter.sv -----
// Top level of the keyed Feistel index permuter with cycle walking.
// A pass is R rounds, a combine and a range test, R = round_count rounded up to even;
// cycle walking repeats passes until the result is below domain_range, at most 65536 passes.
// One item at a time: the next item is taken only once the last has gone to the output
// register, which waits while an earlier result is still held without out_ready.
// Reset (synchronous, active low) restores the default registers and empties the block.
`timescale 1ns / 1ps
module feistel_index_permuter #(
  parameter int unsigned INDEX_WIDTH = 62
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [2:0]             cfg_index,
  input  logic [63:0]            cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [INDEX_WIDTH-1:0] in_plain_index,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [INDEX_WIDTH-1:0] out_shuffled_index
);

  // Configuration registers, written by the user only while the block is idle; not enforced.
  logic [62:0] domain_range_r;
  logic [5:0]  low_half_bits_r, high_half_bits_r, round_count_r;
  logic [63:0] key_seed_r;

  fepr_pkg::dp_cmd_t    cmd;
  fepr_pkg::dp_status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      domain_range_r   <= 63'd1;
      low_half_bits_r  <= 6'd1;
      high_half_bits_r <= 6'd1;
      round_count_r    <= 6'd6;
      key_seed_r       <= 64'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fepr_pkg::REG_DOMAIN_RANGE:   domain_range_r   <= cfg_wdata[62:0];
        fepr_pkg::REG_LOW_HALF_BITS:  low_half_bits_r  <= cfg_wdata[5:0];
        fepr_pkg::REG_HIGH_HALF_BITS: high_half_bits_r <= cfg_wdata[5:0];
        fepr_pkg::REG_ROUND_COUNT:    round_count_r    <= cfg_wdata[5:0];
        fepr_pkg::REG_KEY_SEED:       key_seed_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The controller walks rounds and passes; the datapath holds the halves.
  fepr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .round_count (round_count_r),
    .cmd         (cmd),
    .status      (status)
  );

  fepr_dpath #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .cmd            (cmd),
    .status         (status),
    .domain_range   (domain_range_r),
    .low_half_bits  (low_half_bits_r),
    .high_half_bits (high_half_bits_r),
    .key_seed       (key_seed_r),
    .in_index       (in_plain_index),
    .out_index      (out_shuffled_index)
  );

endmodule

// ----- hdl/fepr_dpath.sv -----
// Datapath of the index permuter: Feistel halves, rotating key, pass result and output register.
`timescale 1ns / 1ps
module fepr_dpath #(
  parameter int unsigned INDEX_WIDTH = 62
) (
  input  logic                     clk,
  input  fepr_pkg::dp_cmd_t        cmd,
  output fepr_pkg::dp_status_t     status,
  input  logic [62:0]              domain_range,
  input  logic [5:0]               low_half_bits,
  input  logic [5:0]               high_half_bits,
  input  logic [63:0]              key_seed,
  input  logic [INDEX_WIDTH-1:0]   in_index,
  output logic [INDEX_WIDTH-1:0]   out_index
);

  logic [63:0] lo_r, hi_r, key_r, c_r;
  logic [INDEX_WIDTH-1:0] out_r;
  logic [63:0] amask, bmask, src, mixed;

  assign amask = (64'd1 << low_half_bits) - 64'd1;
  assign bmask = (64'd1 << high_half_bits) - 64'd1;
  assign src = cmd.load_c ? c_r : 64'(in_index);
  assign mixed = 64'(fepr_pkg::round_mix(hi_r ^ key_r, cmd.round_odd));

  always_ff @(posedge clk) begin
    if (cmd.load_in || cmd.load_c) begin
      lo_r  <= src & amask;
      hi_r  <= src >> low_half_bits;
      key_r <= {key_seed[0], key_seed[63:1]};
    end else if (cmd.do_round) begin
      lo_r  <= hi_r;
      hi_r  <= (lo_r + mixed) & (cmd.round_odd ? amask : bmask);
      key_r <= {key_r[0], key_r[63:1]};
    end
    if (cmd.combine) begin
      c_r <= (hi_r << low_half_bits) + lo_r;
    end
    if (cmd.load_out) begin
      out_r <= cmd.out_zero ? '0 : c_r[INDEX_WIDTH-1:0];
    end
  end

  assign status.below = c_r < {1'b0, domain_range};
  assign out_index = out_r;

endmodule

// ----- hdl/fepr_ctrl.sv -----
// Controller of the index permuter: sequences rounds and passes and owns both handshakes.
`timescale 1ns / 1ps
module fepr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  logic [5:0]           round_count,
  output fepr_pkg::dp_cmd_t    cmd,
  input  fepr_pkg::dp_status_t status
);

  typedef enum logic [1:0] {S_IDLE, S_ROUND, S_COMBINE, S_TEST} state_t;

  state_t state_r;
  logic [fepr_pkg::RoundCntW-1:0] cnt_r, rounds_total;
  logic [fepr_pkg::PassW-1:0] passes_r;
  logic out_valid_r;
  logic finish, out_free;

  // Rounds run in pairs, so an odd count is rounded up.
  assign rounds_total = ({1'b0, round_count} + 7'd1) & 7'h7E;
  assign finish = status.below || (passes_r == fepr_pkg::WALK_LIMIT);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE:    cmd.load_in = in_valid;
      S_ROUND: begin
        cmd.do_round  = 1'b1;
        cmd.round_odd = cnt_r[0];
      end
      S_COMBINE: cmd.combine = 1'b1;
      S_TEST: begin
        cmd.load_out = finish && out_free;
        cmd.out_zero = !status.below;
        cmd.load_c   = !finish;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      passes_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A new result takes the output register; otherwise an accepted one leaves it.
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            passes_r <= 17'd1;
            cnt_r    <= 7'd1;
            state_r  <= (rounds_total == '0) ? S_COMBINE : S_ROUND;
          end
        end
        S_ROUND: begin
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == rounds_total) begin
            state_r <= S_COMBINE;
          end
        end
        S_COMBINE: state_r <= S_TEST;
        S_TEST: begin
          if (finish) begin
            if (out_free) begin
              state_r <= S_IDLE;
            end
          end else begin
            passes_r <= passes_r + 17'd1;
            cnt_r    <= 7'd1;
            state_r  <= (rounds_total == '0) ? S_COMBINE : S_ROUND;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- hdl/fepr_checker.sv -----
// Port-level checks of the index permuter and their binding to the top level.
`timescale 1ns / 1ps
module fepr_checker #(
  parameter int unsigned INDEX_WIDTH = 62
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [INDEX_WIDTH-1:0] out_shuffled_index
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped before acceptance");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_shuffled_index))
    else $error("stalled result item changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind feistel_index_permuter fepr_checker #(.INDEX_WIDTH(INDEX_WIDTH)) u_fepr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_shuffled_index (out_shuffled_index)
);
